>>> sv/qra_pkg.sv
// Shared types, widths and constants for the quaternion running average block.
// Used by every module of the block; depends on nothing.
package qra_pkg;

  localparam int FRAC_BITS_DEF = 14;   // default fraction bits (Q2.14)
  localparam int QW            = 16;   // width of one quaternion component
  localparam int SW            = QW + 1;          // width of one sum component
  localparam int PW            = 2 * SW;          // width of the shared product
  localparam int DOTW          = 2 * QW + 3;      // dot product accumulator
  localparam int SQCW          = 2 * QW + 1;      // square of one sum component
  localparam int SQW           = 2 * QW + 3;      // sum of the four squares
  localparam int NLANE         = 4;               // w, x, y, z
  localparam int IDXW          = $clog2(NLANE);
  localparam int ROOT_STEPS    = QW;              // one result bit per step
  localparam int CNTW          = $clog2(ROOT_STEPS);

  // Largest magnitudes that the signed output field can hold.
  localparam logic [SW-1:0] MAG_POS_MAX = SW'((1 << (QW - 1)) - 1);
  localparam logic [SW-1:0] MAG_NEG_MAX = SW'(1 << (QW - 1));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOT,
    ST_SQ,
    ST_RINIT,
    ST_ROOT,
    ST_NORM,
    ST_EMIT
  } qra_state_t;

  typedef struct packed {
    logic            take;       // capture the accepted quaternion
    logic            load_avg;   // load the average with the accepted quaternion
    logic            dot_en;     // accumulate one dot product term
    logic            sq_en;      // form one sum component and its square
    logic [IDXW-1:0] idx;        // component being worked on
    logic            root_init;  // start the normalization lanes
    logic            root_step;  // one result bit in every lane
    logic            norm_wr;    // write the normalized average
    logic            out_wr;     // copy the average into the output register
  } qra_cmd_t;

endpackage

>>> sv/qra_root_lane.sv
// One normalization lane: finds round(mag * 2^FRAC_BITS / sqrt(S)) one bit per step.
// Depends on qra_pkg.
module qra_root_lane #(
  parameter int FRAC_BITS = qra_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          init,
  input  logic                          step,
  input  logic [qra_pkg::SQW-1:0]       sq,
  input  logic [qra_pkg::SQCW-1:0]      sqc,
  output logic [qra_pkg::ROOT_STEPS-1:0] k
);
  import qra_pkg::*;

  // Wide enough for sqc << (2F+2) and for the candidate (2k-1)^2 * S.
  localparam int AW = (2 * FRAC_BITS + 38 > 72) ? 2 * FRAC_BITS + 38 : 72;

  // The candidate for bit b is t'^2*S with t' = t + 2^(b+1), t = 2k-1:
  // t'^2*S = t^2*S + 2^(b+2)*t*S + 2^(2b+2)*S. The two scaled terms are kept
  // already shifted (qs, ss) so that each step needs only constant shifts.
  logic signed [AW-1:0] p;
  logic signed [AW-1:0] qs;
  logic signed [AW-1:0] ss;
  logic signed [AW-1:0] sq_ext;
  logic signed [AW-1:0] lim;
  logic signed [AW-1:0] cand;
  logic signed [AW-1:0] qs_upd;
  logic                 fits;

  assign sq_ext = signed'({{(AW - SQW){1'b0}}, sq});
  assign lim    = signed'({{(AW - SQCW){1'b0}}, sqc}) <<< (2 * FRAC_BITS + 2);
  assign cand   = p + qs + ss;
  assign fits   = (cand <= lim);
  assign qs_upd = fits ? (qs + (ss <<< 1)) : qs;

  always_ff @(posedge clk) begin
    if (init) begin
      p  <= sq_ext;
      qs <= -(sq_ext <<< (ROOT_STEPS + 1));
      ss <= sq_ext <<< (2 * ROOT_STEPS);
      k  <= '0;
    end else if (step) begin
      if (fits) begin
        p <= cand;
      end
      qs <= qs_upd >>> 1;
      ss <= ss >>> 2;
      k  <= {k[ROOT_STEPS-2:0], fits};
    end
  end

endmodule

>>> sv/qra_dp.sv
// Datapath: input and average registers, shared multiplier, dot and square
// accumulators, four normalization lanes and the output register. Depends on qra_pkg.
module qra_dp #(
  parameter int FRAC_BITS = qra_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic signed [qra_pkg::QW-1:0]   q_w,
  input  logic signed [qra_pkg::QW-1:0]   q_x,
  input  logic signed [qra_pkg::QW-1:0]   q_y,
  input  logic signed [qra_pkg::QW-1:0]   q_z,
  input  qra_pkg::qra_cmd_t               cmd,
  output logic signed [qra_pkg::QW-1:0]   avg_w,
  output logic signed [qra_pkg::QW-1:0]   avg_x,
  output logic signed [qra_pkg::QW-1:0]   avg_y,
  output logic signed [qra_pkg::QW-1:0]   avg_z
);
  import qra_pkg::*;

  logic signed [QW-1:0]   q_in   [NLANE];
  logic signed [QW-1:0]   qv     [NLANE];
  logic signed [QW-1:0]   avg    [NLANE];
  logic signed [QW-1:0]   avg_nx [NLANE];
  logic signed [SW-1:0]   s      [NLANE];
  logic        [SQCW-1:0] sqc    [NLANE];
  logic        [ROOT_STEPS-1:0] lane_k [NLANE];
  logic signed [DOTW-1:0] dot;
  logic        [SQW-1:0]  sq;

  logic signed [SW-1:0]   a_sel;
  logic signed [SW-1:0]   b_sel;
  logic signed [SW-1:0]   s_cur;
  logic signed [PW-1:0]   prod;
  logic                   aligned;

  assign q_in[0] = q_w;
  assign q_in[1] = q_x;
  assign q_in[2] = q_y;
  assign q_in[3] = q_z;

  // A positive dot product adds the new quaternion; zero or negative subtracts.
  assign aligned = (dot > 0);

  always_comb begin
    if (aligned) begin
      s_cur = SW'(avg[cmd.idx]) + SW'(qv[cmd.idx]);
    end else begin
      s_cur = SW'(avg[cmd.idx]) - SW'(qv[cmd.idx]);
    end
    if (cmd.sq_en) begin
      a_sel = s_cur;
      b_sel = s_cur;
    end else begin
      a_sel = SW'(avg[cmd.idx]);
      b_sel = SW'(qv[cmd.idx]);
    end
  end

  assign prod = a_sel * b_sel;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      dot <= '0;
      sq  <= '0;
      for (int i = 0; i < NLANE; i++) begin
        qv[i] <= q_in[i];
      end
    end
    if (cmd.dot_en) begin
      dot <= dot + DOTW'(prod);
    end
    if (cmd.sq_en) begin
      s[cmd.idx]   <= s_cur;
      sqc[cmd.idx] <= prod[SQCW-1:0];
      sq           <= sq + SQW'(unsigned'(prod));
    end
    for (int i = 0; i < NLANE; i++) begin
      if (cmd.load_avg) begin
        avg[i] <= q_in[i];
      end else if (cmd.norm_wr) begin
        avg[i] <= avg_nx[i];
      end
    end
    if (cmd.out_wr) begin
      avg_w <= avg[0];
      avg_x <= avg[1];
      avg_y <= avg[2];
      avg_z <= avg[3];
    end
  end

  for (genvar g = 0; g < NLANE; g++) begin : g_lane
    logic [SW-1:0] mag;

    qra_root_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .init (cmd.root_init),
      .step (cmd.root_step),
      .sq   (sq),
      .sqc  (sqc[g]),
      .k    (lane_k[g])
    );

    // Restore the sign and clamp to the output field; a zero component stays zero.
    always_comb begin
      mag = SW'(lane_k[g]);
      if (s[g] == '0) begin
        avg_nx[g] = '0;
      end else if (s[g] < 0) begin
        if (mag > MAG_NEG_MAX) begin
          mag = MAG_NEG_MAX;
        end
        avg_nx[g] = QW'(-mag);
      end else begin
        if (mag > MAG_POS_MAX) begin
          mag = MAG_POS_MAX;
        end
        avg_nx[g] = QW'(mag);
      end
    end
  end

endmodule

>>> sv/qra_ctrl.sv
// Controller: state machine that sequences the datapath, tracks the open set
// and owns both handshakes. Depends on qra_pkg.
module qra_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              first_of_set,
  input  logic              last_of_set,
  output logic              out_valid,
  input  logic              out_ready,
  output qra_pkg::qra_cmd_t cmd
);
  import qra_pkg::*;

  qra_state_t      state;
  qra_state_t      state_next;
  logic [CNTW-1:0] cnt;
  logic [CNTW-1:0] cnt_next;
  logic            set_open;
  logic            set_open_next;
  logic            last_q;
  logic            out_valid_next;
  logic            take;
  logic            load;
  logic            out_free;

  assign take     = (state == ST_IDLE) && in_valid;
  assign load     = first_of_set || !set_open;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (load) begin
            state_next = last_of_set ? ST_EMIT : ST_IDLE;
          end else begin
            state_next = ST_DOT;
          end
        end
      end
      ST_DOT: begin
        if (cnt == CNTW'(NLANE - 1)) begin
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        if (cnt == CNTW'(NLANE - 1)) begin
          state_next = ST_RINIT;
        end
      end
      ST_RINIT: state_next = ST_ROOT;
      ST_ROOT: begin
        if (cnt == CNTW'(ROOT_STEPS - 1)) begin
          state_next = ST_NORM;
        end
      end
      ST_NORM: state_next = last_q ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == ST_IDLE);
    cmd           = '0;
    cmd.take      = take;
    cmd.load_avg  = take && load;
    cmd.dot_en    = (state == ST_DOT);
    cmd.sq_en     = (state == ST_SQ);
    cmd.idx       = cnt[IDXW-1:0];
    cmd.root_init = (state == ST_RINIT);
    cmd.root_step = (state == ST_ROOT);
    cmd.norm_wr   = (state == ST_NORM);
    cmd.out_wr    = (state == ST_EMIT) && out_free;
  end

  always_comb begin
    cnt_next = '0;
    if (state_next == state && state != ST_IDLE && state != ST_EMIT) begin
      cnt_next = cnt + 1'b1;
    end
    set_open_next = set_open;
    if (take) begin
      set_open_next = 1'b1;
    end else if (cmd.out_wr) begin
      set_open_next = 1'b0;
    end
    out_valid_next = out_valid;
    if (cmd.out_wr) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      set_open  <= 1'b0;
      last_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      set_open  <= set_open_next;
      out_valid <= out_valid_next;
      if (take) begin
        last_q <= last_of_set;
      end
    end
  end

endmodule

>>> sv/quaternion_running_average_top.sv
// Top level of the quaternion running average block.
// Joins the controller (qra_ctrl) and the datapath (qra_dp); depends on qra_pkg.
//
// This block averages unit quaternions in Q2.14 (FRAC_BITS fraction bits) over
// sets of input transactions. The first transaction of a set, or any transaction
// that arrives while no set is open, loads the running average unchanged. Every
// later transaction keeps the block busy from its acceptance until it is ready
// again: the shared 17x17 multiplier first forms the dot product with the
// average, then the aligned sum and its squares; then the four normalization
// lanes are started, each lane settles one output bit of the rounded, normalized
// component per step, and the new average is written. A transaction with
// last_of_set set passes through an emit state that moves the average into
// the output register, and that state waits while the previous result is still
// held there. The output register lets the next transaction be accepted while a
// finished result waits to be taken. A sum of zero length gives an all-zero
// average, and normalized components are clamped to the output field.
module quaternion_running_average_top #(
  parameter int FRAC_BITS = qra_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [qra_pkg::QW-1:0] q_w,
  input  logic signed [qra_pkg::QW-1:0] q_x,
  input  logic signed [qra_pkg::QW-1:0] q_y,
  input  logic signed [qra_pkg::QW-1:0] q_z,
  input  logic                          first_of_set,
  input  logic                          last_of_set,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [qra_pkg::QW-1:0] avg_w,
  output logic signed [qra_pkg::QW-1:0] avg_x,
  output logic signed [qra_pkg::QW-1:0] avg_y,
  output logic signed [qra_pkg::QW-1:0] avg_z
);
  import qra_pkg::*;

  // Commands from the controller to the datapath; the datapath reports nothing
  // back because every step has a fixed length.
  qra_cmd_t cmd;

  qra_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .first_of_set (first_of_set),
    .last_of_set  (last_of_set),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd)
  );

  // The datapath holds the running average, the arithmetic and the output
  // register whose contents are valid while out_valid is high.
  qra_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk   (clk),
    .q_w   (q_w),
    .q_x   (q_x),
    .q_y   (q_y),
    .q_z   (q_z),
    .cmd   (cmd),
    .avg_w (avg_w),
    .avg_x (avg_x),
    .avg_y (avg_y),
    .avg_z (avg_z)
  );

endmodule

>>> verif/tb_quaternion_running_average_top.sv
// Self-checking testbench for quaternion_running_average_top.
// It holds its own model of the set averaging, drives both handshakes under
// several idle and stall patterns, and depends on qra_pkg and the block's RTL.
module tb_quaternion_running_average_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qra_pkg::*;

  localparam int FRAC_BITS = FRAC_BITS_DEF;

  // One quaternion, component 0 is w, then x, y, z.
  typedef logic [NLANE-1:0][QW-1:0] quat_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [QW-1:0] q_w = '0;
  logic signed [QW-1:0] q_x = '0;
  logic signed [QW-1:0] q_y = '0;
  logic signed [QW-1:0] q_z = '0;
  logic                 first_of_set = 1'b0;
  logic                 last_of_set = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [QW-1:0] avg_w;
  logic signed [QW-1:0] avg_x;
  logic signed [QW-1:0] avg_y;
  logic signed [QW-1:0] avg_z;

  // Model state: the running average and whether a set is open.
  quat_t avg_model = '0;
  bit    set_open_model = 1'b0;

  // Averages that the block still owes us, oldest first.
  quat_t expected_avgs[$];

  int send_idle_pct = 0;   // chance in percent that the sender idles a cycle
  int recv_stall_pct = 0;  // chance in percent that the receiver stalls a cycle
  int quats_sent = 0;
  int avgs_checked = 0;
  int mismatch_count = 0;

  quaternion_running_average_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .q_w          (q_w),
    .q_x          (q_x),
    .q_y          (q_y),
    .q_z          (q_z),
    .first_of_set (first_of_set),
    .last_of_set  (last_of_set),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .avg_w        (avg_w),
    .avg_x        (avg_x),
    .avg_y        (avg_y),
    .avg_z        (avg_z)
  );

  always #2 clk = ~clk;

  // Magnitude of one normalized component: the largest k in 0..32768 with
  // (2k-1)^2 * sq <= 4 * mag^2 * 2^(2*FRAC_BITS), which is |s| * 2^FRAC_BITS
  // / sqrt(sq) rounded to nearest with ties away from zero. The products
  // reach about 2^66, so the comparison is done on 128-bit vectors.
  function automatic int unsigned unit_scaled_mag(input longint unsigned mag,
                                                  input longint unsigned sq);
    logic [127:0]      num;
    logic [127:0]      den;
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       k;
    longint unsigned   t;
    if (mag == 0) begin
      return 0;
    end
    lo = 0;
    hi = 32768;
    num = (128'(mag) * 128'(mag) * 128'(4)) << (2 * FRAC_BITS);
    while (lo < hi) begin
      k = (lo + hi + 1) / 2;
      t = 2 * longint'(k) - 1;
      den = 128'(t) * 128'(t) * 128'(sq);
      if (num >= den) begin
        lo = k;
      end else begin
        hi = k - 1;
      end
    end
    return lo;
  endfunction

  // Folds one accepted quaternion into the model average. The first item of
  // a set, or any item while no set is open, loads the average unchanged.
  // A later item is added when its dot product with the average is positive
  // and subtracted otherwise; the sum is then normalized. A sum of zero
  // length leaves the average all zero. Closing a set queues the average.
  function automatic void fold_into_average(input quat_t q, input bit first,
                                            input bit last);
    longint          dot;
    longint          a;
    longint          b;
    longint          s[NLANE];
    longint unsigned sq;
    longint          m;
    int              i;
    if (first || !set_open_model) begin
      avg_model = q;
    end else begin
      dot = 0;
      for (i = 0; i < NLANE; i++) begin
        a = $signed(avg_model[i]);
        b = $signed(q[i]);
        dot += a * b;
      end
      sq = 0;
      for (i = 0; i < NLANE; i++) begin
        a = $signed(avg_model[i]);
        b = $signed(q[i]);
        s[i] = (dot > 0) ? a + b : a - b;
        sq += longint'(s[i] * s[i]);
      end
      for (i = 0; i < NLANE; i++) begin
        if (sq == 0) begin
          avg_model[i] = '0;
        end else begin
          m = unit_scaled_mag((s[i] < 0) ? -s[i] : s[i], sq);
          if (s[i] < 0) begin
            m = -m;
          end
          // Unit-length sums stay within range here; the clamp only guards
          // the 16-bit field.
          if (m > 32767) begin
            m = 32767;
          end else if (m < -32768) begin
            m = -32768;
          end
          avg_model[i] = m[QW-1:0];
        end
      end
    end
    set_open_model = 1'b1;
    if (last) begin
      set_open_model = 1'b0;
      expected_avgs.insert(expected_avgs.size(), avg_model);
    end
  endfunction

  // Watches both channels at every rising edge. Values read here are the
  // ones from before the edge, since every driver uses nonblocking updates.
  // The output side is checked first; a result can never belong to an input
  // transaction accepted at the same edge.
  always @(posedge clk) begin
    quat_t got;
    quat_t want;
    string field_names[NLANE];
    field_names = '{"avg_w", "avg_x", "avg_y", "avg_z"};
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = {avg_z, avg_y, avg_x, avg_w};
        if (expected_avgs.size() == 0) begin
          $error("average w=%0d x=%0d y=%0d z=%0d arrived with none expected",
                 avg_w, avg_x, avg_y, avg_z);
          mismatch_count++;
        end else begin
          want = expected_avgs.pop_front();
          avgs_checked++;
          for (int i = 0; i < NLANE; i++) begin
            if (got[i] !== want[i]) begin
              $error("%s: expected %0d, got %0d", field_names[i],
                     $signed(want[i]), $signed(got[i]));
              mismatch_count++;
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        fold_into_average({q_z, q_y, q_x, q_w}, first_of_set, last_of_set);
      end
    end
  end

  // The receiver stalls at random with the chance set for the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic quat_t quat(input int w, input int x, input int y, input int z);
    return {QW'(z), QW'(y), QW'(x), QW'(w)};
  endfunction

  // A near-unit quaternion around a center: every component of the center is
  // moved by up to spread, and the result is scaled to length 2^FRAC_BITS.
  function automatic quat_t near_unit(input quat_t center, input int spread);
    real   v[NLANE];
    real   len;
    quat_t q;
    int    i;
    len = 0.0;
    for (i = 0; i < NLANE; i++) begin
      v[i] = real'(int'($signed(center[i])) + int'($urandom_range(0, 2 * spread))
                   - spread);
      len += v[i] * v[i];
    end
    if (len < 1.0) begin
      v[0] = 1.0;
      len = 1.0;
    end
    len = $sqrt(len);
    for (i = 0; i < NLANE; i++) begin
      q[i] = QW'(int'(v[i] * real'(1 << FRAC_BITS) / len));
    end
    return q;
  endfunction

  // Presents one input transaction and returns at the edge that accepts it,
  // or after a random idle stretch that follows. Valid stays high when no
  // idle cycle is drawn, so back-to-back transactions keep it raised.
  task automatic send_quat(input quat_t q, input bit first, input bit last);
    q_w <= q[0];
    q_x <= q[1];
    q_y <= q[2];
    q_z <= q[3];
    first_of_set <= first;
    last_of_set <= last;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    quats_sent++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  // Sets of one item, including raw values outside the unit range, and an
  // item with no set open and no first flag, which must start a new set.
  task automatic test_single_item_sets();
    send_quat(quat(16384, 0, 0, 0), 1'b1, 1'b1);
    send_quat(quat(-16384, 16384, -16384, 16384), 1'b1, 1'b1);
    send_quat(quat(32767, -32768, 0, -1), 1'b1, 1'b1);
    send_quat(quat(0, 0, 16384, 0), 1'b0, 1'b1);
  endtask

  // The sign rule for alignment, the zero-length sum, and a first flag in the
  // middle of an open set.
  task automatic test_alignment_and_zero_length();
    // A dot product of exactly zero subtracts.
    send_quat(quat(16384, 0, 0, 0), 1'b1, 1'b0);
    send_quat(quat(0, 16384, 0, 0), 1'b0, 1'b0);
    send_quat(quat(11585, -11585, 0, 0), 1'b0, 1'b1);
    // A negative dot product flips the item back onto the average.
    send_quat(quat(0, 0, 16384, 0), 1'b1, 1'b0);
    send_quat(quat(0, 0, -16384, 0), 1'b0, 1'b1);
    // Zero plus zero has no length, and the average stays all zero.
    send_quat(quat(0, 0, 0, 0), 1'b1, 1'b0);
    send_quat(quat(0, 0, 0, 0), 1'b0, 1'b0);
    send_quat(quat(0, 0, 0, 0), 1'b0, 1'b1);
    // A zero average against a real item: the dot is zero, so it subtracts.
    send_quat(quat(0, 0, 0, 0), 1'b1, 1'b0);
    send_quat(quat(1000, -2000, 3000, -4000), 1'b0, 1'b1);
    // A first flag restarts a set that is still open.
    send_quat(quat(16384, 0, 0, 0), 1'b1, 1'b0);
    send_quat(quat(0, 0, 0, 16384), 1'b1, 1'b1);
  endtask

  // The widest sums the arithmetic can see, and the smallest nonzero ones.
  task automatic test_extreme_components();
    send_quat(quat(32767, -32768, 32767, -32768), 1'b1, 1'b0);
    send_quat(quat(-32768, 32767, -32768, 32767), 1'b0, 1'b0);
    send_quat(quat(32767, 32767, 32767, 32767), 1'b0, 1'b0);
    send_quat(quat(-32768, -32768, -32768, -32768), 1'b0, 1'b1);
    send_quat(quat(1, 0, 0, 0), 1'b1, 1'b0);
    send_quat(quat(0, 0, 0, -1), 1'b0, 1'b1);
  endtask

  // Random traffic under one idle and stall pattern. Most transactions form
  // well-made sets of near-unit quaternions scattered around a random center,
  // a quarter of them with their sign flipped. Some sets lose their first or
  // last flag, and a share of transactions carry raw 16-bit noise with
  // random flags.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int num_quats);
    int    sent;
    int    kind;
    int    len;
    int    spread;
    quat_t base;
    quat_t q;
    bit    first;
    bit    last;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < num_quats) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        send_quat(quat_t'({$urandom, $urandom}), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        sent++;
      end else begin
        len = (kind < 20) ? $urandom_range(9, 20) : $urandom_range(1, 6);
        spread = $urandom_range(100, 6000);
        base = near_unit('0, 1 << FRAC_BITS);
        for (int j = 0; j < len; j++) begin
          q = (j == 0) ? base : near_unit(base, spread);
          if ($urandom_range(0, 3) == 0) begin
            for (int i = 0; i < NLANE; i++) begin
              q[i] = -$signed(q[i]);
            end
          end
          first = (j == 0) && ($urandom_range(0, 9) != 0);
          last = (j == len - 1) && ($urandom_range(0, 19) != 0);
          send_quat(q, first, last);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_single_item_sets();
    test_alignment_and_zero_length();
    test_extreme_components();

    // Pressure phases: none, sender mostly idle, receiver mostly stalled,
    // and both sides idling at a moderate rate.
    test_random_traffic(0, 0, 257);
    test_random_traffic(88, 0, 257);
    test_random_traffic(0, 88, 257);
    test_random_traffic(30, 30, 257);
    in_valid <= 1'b0;
    recv_stall_pct = 0;

    // Drain the owed averages, then give a last transaction without a
    // result time to finish its full normalization pass.
    while (expected_avgs.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);

    $display("Sent %0d quaternions in directed cases and four pressure phases;",
             quats_sent);
    $display("compared %0d set averages field by field.", avgs_checked);
    if (mismatch_count == 0) begin
      $display("quaternion_running_average_top: match");
    end else begin
      $display("quaternion_running_average_top: mismatch");
    end
    $finish;
  end

  // A correct run takes well under a tenth of this time.
  initial begin
    #2000000;
    $display("Timed out with %0d averages still owed.", expected_avgs.size());
    $display("quaternion_running_average_top: mismatch");
    $finish;
  end

endmodule
